### design/psc_pkg.sv
`default_nettype none

package psc_pkg;

	// Field widths
	localparam int COUNT_BITS = 16;
	localparam int GAIN_W     = 14;
	localparam int SPEED_W    = 18;
	localparam int ERR_W      = 19;
	localparam int DERR_W     = ERR_W + 1;
	localparam int PPROD_W    = ERR_W + GAIN_W;
	localparam int DPROD_W    = DERR_W + GAIN_W;
	localparam int PD_W       = DPROD_W + 1;
	localparam int INTEG_W    = 48;
	localparam int SUM_W      = INTEG_W + 1;
	localparam int DRIVE_W    = 10;
	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 32;
	localparam int CFG_IDX_W  = 2;

	// Output limits
	localparam int DRIVE_MAX  = 1023;
	localparam int SPEED_MAX  = 245756;
	localparam int GAIN_SCALE = 10000;

	// Truncated quotient of the PID sum is clamped, so only sums in
	// [GAIN_SCALE, QUOT_LIMIT) need a real divide; those fit QUOT_X_W bits.
	localparam int QUOT_LIMIT = (DRIVE_MAX + 1) * GAIN_SCALE;
	localparam int QUOT_X_W   = 24;
	// ceil(2^37 / 10000); x * RECIP >> 37 is exact for x < 2^24
	localparam int RECIP_SHIFT = 37;
	localparam int RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP = 24'd13743896;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN    = 2'd0,
		REG_INTEG_GAIN   = 2'd1,
		REG_DERIV_GAIN   = 2'd2,
		REG_TARGET_SPEED = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

### design/pid_speed_controller_core.sv
`default_nettype none

// PID motor speed controller. Each slave transaction is one sample period
// carrying the encoder pulse count; each master transaction returns the
// clamped PWM drive level (1..1023) and the measured speed in rpm
// (floor(count * 3.75)). Gains are in units of 1/10000; the integral
// accumulator is 48 bits and saturates instead of wrapping. The datapath is
// a five-stage pipeline (input, products, integral/sum parts, PID sum and
// clamp decode, reciprocal divide into the output register), so a result
// is offered on the master side once it reaches the output register, and one
// transaction can be taken every cycle while s_tready is high. Each stage
// fills a bubble on its own, so the slave side keeps accepting while a result
// waits at the master side, until all five stages hold an item. Gains and
// setpoint are written through cfg_we/cfg_index/cfg_data and must only
// change while the pipeline is empty.
module pid_speed_controller_core (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic                                cfg_we,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [psc_pkg::GAIN_W-1:0]          cfg_data,

	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [15:0] pulse_count
	input  wire logic [psc_pkg::TDATA_IN_W-1:0]      s_tdata,

	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [9:0] drive_level, [27:10] measured_speed, [31:28] zero
	output logic [psc_pkg::TDATA_OUT_W-1:0]          m_tdata
);

	localparam int PADW = psc_pkg::TDATA_OUT_W - psc_pkg::DRIVE_W - psc_pkg::SPEED_W;
	localparam int RPROD_W = psc_pkg::QUOT_X_W + psc_pkg::RECIP_W;

	// Configuration registers
	logic [psc_pkg::GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, target_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			target_speed_q <= '0;
		end else if (cfg_we) begin
			unique case (psc_pkg::cfg_reg_t'(cfg_index))
				psc_pkg::REG_PROP_GAIN:    prop_gain_q    <= cfg_data;
				psc_pkg::REG_INTEG_GAIN:   integ_gain_q   <= cfg_data;
				psc_pkg::REG_DERIV_GAIN:   deriv_gain_q   <= cfg_data;
				psc_pkg::REG_TARGET_SPEED: target_speed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage valids and per-stage ready (a stage loads when empty or draining)
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || m_tready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: input register
	logic [psc_pkg::COUNT_BITS-1:0] count_s1;

	always_ff @(posedge clk) begin
		if (rdy1) count_s1 <= s_tdata[psc_pkg::COUNT_BITS-1:0];
	end

	// Stage 1 -> 2: speed, error, gain products
	logic [psc_pkg::SPEED_W+1:0]          count15;
	logic [psc_pkg::SPEED_W-1:0]          speed;
	logic signed [psc_pkg::ERR_W-1:0]     err;
	logic signed [psc_pkg::DERR_W-1:0]    derr;
	logic signed [psc_pkg::ERR_W-1:0]     last_err_q;

	// count * 15 = count * 16 - count
	assign count15 = {count_s1, 4'b0000} - {4'b0000, count_s1};
	assign speed   = count15[psc_pkg::SPEED_W+1:2];
	assign err     = signed'({{(psc_pkg::ERR_W - psc_pkg::GAIN_W){1'b0}}, target_speed_q})
	               - signed'({1'b0, speed});
	assign derr    = psc_pkg::DERR_W'(err) - psc_pkg::DERR_W'(last_err_q);

	logic [psc_pkg::SPEED_W-1:0]          speed_s2;
	logic signed [psc_pkg::PPROD_W-1:0]   pprod_s2;
	logic signed [psc_pkg::PPROD_W-1:0]   iprod_s2;
	logic signed [psc_pkg::DPROD_W-1:0]   dprod_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			speed_s2 <= speed;
			pprod_s2 <= psc_pkg::PPROD_W'(signed'({1'b0, prop_gain_q}))
			          * psc_pkg::PPROD_W'(err);
			iprod_s2 <= psc_pkg::PPROD_W'(signed'({1'b0, integ_gain_q}))
			          * psc_pkg::PPROD_W'(err);
			dprod_s2 <= psc_pkg::DPROD_W'(signed'({1'b0, deriv_gain_q}))
			          * psc_pkg::DPROD_W'(derr);
		end
	end

	// Last error follows items in order as they leave stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_err_q <= '0;
		else if (v_s1 && rdy2)
			last_err_q <= err;
	end

	// Stage 2 -> 3: saturating integral, P + D
	logic signed [psc_pkg::INTEG_W-1:0] integ_q;
	logic signed [psc_pkg::SUM_W-1:0]   integ_raw;
	logic signed [psc_pkg::INTEG_W-1:0] integ_next;

	assign integ_raw = psc_pkg::SUM_W'(integ_q) + psc_pkg::SUM_W'(iprod_s2);

	always_comb begin
		// top two bits disagree: result left the 48-bit range
		if (integ_raw[psc_pkg::SUM_W-1] != integ_raw[psc_pkg::SUM_W-2])
			integ_next = integ_raw[psc_pkg::SUM_W-1]
				? {1'b1, {(psc_pkg::INTEG_W-1){1'b0}}}
				: {1'b0, {(psc_pkg::INTEG_W-1){1'b1}}};
		else
			integ_next = integ_raw[psc_pkg::INTEG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			integ_q <= '0;
		else if (v_s2 && rdy3)
			integ_q <= integ_next;
	end

	logic [psc_pkg::SPEED_W-1:0]        speed_s3;
	logic signed [psc_pkg::INTEG_W-1:0] iterm_s3;
	logic signed [psc_pkg::PD_W-1:0]    pd_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			speed_s3 <= speed_s2;
			iterm_s3 <= integ_next;
			pd_s3    <= psc_pkg::PD_W'(pprod_s2) + psc_pkg::PD_W'(dprod_s2);
		end
	end

	// Stage 3 -> 4: PID sum and clamp decode. Truncation toward zero gives
	// a quotient below one for every sum under GAIN_SCALE.
	logic signed [psc_pkg::SUM_W-1:0] pid_sum;
	logic                             sum_lo, sum_hi;

	assign pid_sum = psc_pkg::SUM_W'(iterm_s3) + psc_pkg::SUM_W'(pd_s3);
	assign sum_lo  = pid_sum < psc_pkg::SUM_W'(psc_pkg::GAIN_SCALE);
	assign sum_hi  = pid_sum >= psc_pkg::SUM_W'(psc_pkg::QUOT_LIMIT);

	logic [psc_pkg::SPEED_W-1:0]  speed_s4;
	logic [psc_pkg::QUOT_X_W-1:0] quot_x_s4;
	logic                         lo_s4, hi_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			speed_s4  <= speed_s3;
			quot_x_s4 <= pid_sum[psc_pkg::QUOT_X_W-1:0];
			lo_s4     <= sum_lo;
			hi_s4     <= sum_hi;
		end
	end

	// Stage 4 -> 5: divide by 10000 via reciprocal, then clamp
	logic [RPROD_W-1:0]          recip_prod;
	logic [psc_pkg::DRIVE_W-1:0] quot;
	logic [psc_pkg::DRIVE_W-1:0] drive;

	assign recip_prod = RPROD_W'(quot_x_s4) * RPROD_W'(psc_pkg::RECIP);
	assign quot       = recip_prod[psc_pkg::RECIP_SHIFT +: psc_pkg::DRIVE_W];

	always_comb begin
		if (lo_s4)
			drive = psc_pkg::DRIVE_W'(1);
		else if (hi_s4)
			drive = psc_pkg::DRIVE_W'(psc_pkg::DRIVE_MAX);
		else
			drive = quot;
	end

	logic [psc_pkg::DRIVE_W-1:0] drive_s5;
	logic [psc_pkg::SPEED_W-1:0] speed_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			drive_s5 <= drive;
			speed_s5 <= speed_s4;
		end
	end

	assign m_tdata = {{PADW{1'b0}}, speed_s5, drive_s5};

endmodule

`default_nettype wire

### design/psc_checker.sv
`default_nettype none

module psc_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tready,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [psc_pkg::TDATA_OUT_W-1:0]     m_tdata
);

	localparam int SPD_LSB = psc_pkg::DRIVE_W;
	localparam int SPD_MSB = psc_pkg::DRIVE_W + psc_pkg::SPEED_W - 1;

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// empty output stage means the whole pipeline can take a transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output empty");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[psc_pkg::DRIVE_W-1:0] != '0)
		else $error("drive level below one");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[SPD_MSB:SPD_LSB] <= psc_pkg::SPEED_W'(psc_pkg::SPEED_MAX))
		else $error("measured speed out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[psc_pkg::TDATA_OUT_W-1:SPD_MSB+1] == '0)
		else $error("tdata padding not zero");

endmodule

bind pid_speed_controller_core psc_checker u_psc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
